// File: src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared definitions of the first-fit block allocator
// Word geometry of the bitmap, command codes, controller states and the
// result of one bitmap word search.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // The bitmap is stored and searched sixteen blocks per memory word.
  localparam int WORD_BITS = 16;
  localparam int WORD_LSB  = 4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_MARK_RD = 5'b00100,
    S_MARK_WR = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

  // Outcome of searching one word: hit position of the first run that reaches
  // the requested length, and the free run still open at the top of the word.
  typedef struct packed {
    logic       hit;
    logic [3:0] pos;
    logic [8:0] carry;
  } scan_res_t;

endpackage

// File: src/ffa_word_scan.sv
// ----------------------------------------------------------------------------
// ffa_word_scan: first-fit search over one bitmap word
// Finds the lowest block at which a free run, continued from the previous
// word, reaches the requested length.
// ----------------------------------------------------------------------------
module ffa_word_scan (
  input  logic [ffa_pkg::WORD_BITS-1:0] free_bits,
  input  logic [8:0]                    carry,
  input  logic [8:0]                    needed,
  output ffa_pkg::scan_res_t            res
);

  logic [ffa_pkg::WORD_BITS-1:0] hit_vec;
  logic [9:0]                    run_top;

  // Each bit position works out its own run length: the distance to the last
  // used bit at or below it, or the carried run plus its offset if there is none.
  always_comb begin
    logic       any_used;
    logic [3:0] last_used;
    logic [9:0] run;
    hit_vec = '0;
    run_top = '0;
    for (int j = 0; j < ffa_pkg::WORD_BITS; j++) begin
      any_used  = 1'b0;
      last_used = '0;
      for (int i = 0; i <= j; i++) begin
        if (!free_bits[i]) begin
          any_used  = 1'b1;
          last_used = 4'(i);
        end
      end
      if (any_used) begin
        run = 10'(j) - 10'(last_used);
      end else begin
        run = 10'(carry) + 10'(j) + 10'd1;
      end
      hit_vec[j] = (run >= 10'(needed));
      if (j == ffa_pkg::WORD_BITS - 1) begin
        run_top = run;
      end
    end
  end

  always_comb begin
    res.hit   = |hit_vec;
    res.pos   = '0;
    // Without a hit the open run is shorter than the request, so it fits.
    res.carry = run_top[8:0];
    for (int j = ffa_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        res.pos = 4'(j);
      end
    end
  end

endmodule

// File: src/first_fit_contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_contiguous_block_allocator: first-fit run allocator over a bitmap
// Allocates and frees runs of contiguous pool blocks kept in a bitmap memory.
// ----------------------------------------------------------------------------
// Usage. Each input word carries a command (allocate or free), a run length
// and, for a free, the first block of the run. Each word yields exactly one
// output word: granted, the start of the granted run, a fragmentation flag
// and the number of blocks in use after the command. Both channels use
// valid/stall; a word moves at a clock edge with valid high and stall low.
// The configuration port writes the pool size in blocks with cfg_we; write
// it only while the allocator is idle.
// Timing. The bitmap sits in a registered-read memory of 16-bit words. An
// allocate scans one word per cycle up to the match (at most one word per 16
// pool blocks, rounded up), then reads the first covered word and
// read-modify-writes the covered words at one word per cycle. A free does
// the same over the words it covers. A zero-length command or an oversized
// allocate goes from idle straight to the finish state. The next input word
// is taken only once the result is out; one item at a time.
// Reset clears the per-word valid bits, so the whole map reads as free at
// once, and sets the pool size to 256 blocks. A stalled output word holds;
// the next input word is accepted meanwhile but its result waits until the
// output register empties.
// ----------------------------------------------------------------------------
module first_fit_contiguous_block_allocator #(
  parameter int NUM_BLOCKS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [8:0] in_block_count,
  input  logic [7:0] in_run_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_granted,
  output logic [7:0] out_granted_start,
  output logic       out_fragmented,
  output logic [8:0] out_in_use_count
);

  localparam int WB    = ffa_pkg::WORD_BITS;
  localparam int WORDS = (NUM_BLOCKS + WB - 1) / WB;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  // Block index width: covers the map and the farthest end of a free run.
  localparam int IW    = (AW + ffa_pkg::WORD_LSB > 10) ? AW + ffa_pkg::WORD_LSB : 10;

  // Bitmap memory and one valid bit per word; a word never written reads free.
  logic [WB-1:0] bitmap_mem [WORDS];
  logic [WB-1:0] mem_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_addr_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WB-1:0] wr_data;
  logic [WORDS-1:0] word_valid_r;
  logic [WB-1:0] rd_data;

  ffa_pkg::state_t state_r, state_nxt;
  logic [8:0]    pool_r, pool_nxt;
  logic [8:0]    total_r, total_nxt;
  logic          op_set_r, op_set_nxt;
  logic [8:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] w_r, w_nxt;
  logic [AW-1:0] end_w_r, end_w_nxt;
  logic [IW-1:0] lo_r, lo_nxt;
  logic [IW-1:0] hi_r, hi_nxt;
  logic [8:0]    carry_r, carry_nxt;
  logic          res_granted_r, res_granted_nxt;
  logic [7:0]    res_start_r, res_start_nxt;
  logic          res_frag_r, res_frag_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_granted_r, out_granted_nxt;
  logic [7:0]    out_start_r, out_start_nxt;
  logic          out_frag_r, out_frag_nxt;
  logic [8:0]    out_count_r, out_count_nxt;

  logic [8:0]    pool_eff;
  logic [WB-1:0] free_bits;
  logic [WB-1:0] run_mask;
  logic [IW-1:0] free_hi_raw;
  logic [IW-1:0] free_hi;
  logic [IW-1:0] free_lo;
  logic [IW-1:0] alloc_start;
  logic [AW-1:0] w_inc;
  logic          last_pool_word;
  logic [8:0]    free_cnt;
  ffa_pkg::scan_res_t scan_res;

  // Pool limited to the map size; the compare is only live for small maps.
  assign pool_eff = (32'(pool_r) > NUM_BLOCKS) ? 9'(NUM_BLOCKS) : pool_r;

  assign rd_data = word_valid_r[rd_addr_q] ? mem_q : '0;
  assign w_inc   = (w_r == AW'(WORDS - 1)) ? '0 : w_r + AW'(1);

  // The current word is the last one that holds blocks of the pool.
  assign last_pool_word = (IW'({w_r, 4'hF}) >= IW'(pool_eff - 9'd1));

  // Free blocks inside the pool; bits past the pool end count as used.
  always_comb begin
    for (int i = 0; i < WB; i++) begin
      free_bits[i] = !rd_data[i] && (IW'({w_r, 4'(i)}) < IW'(pool_eff));
      run_mask[i]  = (IW'({w_r, 4'(i)}) >= lo_r) && (IW'({w_r, 4'(i)}) <= hi_r);
    end
  end

  ffa_word_scan u_scan (
    .free_bits (free_bits),
    .carry     (carry_r),
    .needed    (cnt_r),
    .res       (scan_res)
  );

  assign alloc_start = IW'({w_r, scan_res.pos}) + IW'(1) - IW'(cnt_r);
  assign free_cnt    = (total_r < pool_eff) ? pool_eff - total_r : '0;

  // A free run ends at the last map block at the latest.
  assign free_lo     = IW'(in_run_start);
  assign free_hi_raw = free_lo + IW'(in_block_count) - IW'(1);
  assign free_hi     = (32'(free_hi_raw) >= NUM_BLOCKS) ? IW'(NUM_BLOCKS - 1) : free_hi_raw;

  assign in_stall = (state_r != ffa_pkg::S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    pool_nxt        = cfg_we ? cfg_wdata : pool_r;
    total_nxt       = total_r;
    op_set_nxt      = op_set_r;
    cnt_nxt         = cnt_r;
    w_nxt           = w_r;
    end_w_nxt       = end_w_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    carry_nxt       = carry_r;
    res_granted_nxt = res_granted_r;
    res_start_nxt   = res_start_r;
    res_frag_nxt    = res_frag_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_granted_nxt = out_granted_r;
    out_start_nxt   = out_start_r;
    out_frag_nxt    = out_frag_r;
    out_count_nxt   = out_count_r;
    rd_addr         = w_r;
    wr_en           = 1'b0;
    wr_addr         = w_r;
    wr_data         = rd_data;

    case (state_r)
      ffa_pkg::S_IDLE: begin
        if (in_valid) begin
          res_granted_nxt = 1'b0;
          res_start_nxt   = '0;
          res_frag_nxt    = 1'b0;
          cnt_nxt         = in_block_count;
          carry_nxt       = '0;
          state_nxt       = ffa_pkg::S_FINISH;
          if (in_block_count == '0) begin
            // Zero-length command changes nothing and is not granted.
          end else if (in_command == ffa_pkg::CMD_ALLOC) begin
            op_set_nxt = 1'b1;
            // A request longer than the pool fails with no search.
            if (in_block_count <= pool_eff) begin
              w_nxt     = '0;
              rd_addr   = '0;
              state_nxt = ffa_pkg::S_SCAN;
            end
          end else begin
            op_set_nxt      = 1'b0;
            res_granted_nxt = 1'b1;
            if (32'(in_run_start) < NUM_BLOCKS) begin
              lo_nxt    = free_lo;
              hi_nxt    = free_hi;
              w_nxt     = free_lo[AW+3:4];
              end_w_nxt = free_hi[AW+3:4];
              state_nxt = ffa_pkg::S_MARK_RD;
            end
          end
        end
      end

      ffa_pkg::S_SCAN: begin
        if (scan_res.hit) begin
          lo_nxt          = alloc_start;
          hi_nxt          = IW'({w_r, scan_res.pos});
          w_nxt           = alloc_start[AW+3:4];
          end_w_nxt       = w_r;
          total_nxt       = total_r + cnt_r;
          res_granted_nxt = 1'b1;
          res_start_nxt   = alloc_start[7:0];
          state_nxt       = ffa_pkg::S_MARK_RD;
        end else if (last_pool_word) begin
          res_frag_nxt = (free_cnt >= cnt_r);
          state_nxt    = ffa_pkg::S_FINISH;
        end else begin
          w_nxt     = w_inc;
          rd_addr   = w_inc;
          carry_nxt = scan_res.carry;
        end
      end

      ffa_pkg::S_MARK_RD: begin
        rd_addr   = w_r;
        state_nxt = ffa_pkg::S_MARK_WR;
      end

      ffa_pkg::S_MARK_WR: begin
        // Write back this word while the next one is read.
        wr_en   = 1'b1;
        rd_addr = w_inc;
        if (op_set_r) begin
          wr_data = rd_data | run_mask;
        end else begin
          wr_data   = rd_data & ~run_mask;
          total_nxt = total_r - 9'($countones(rd_data & run_mask));
        end
        if (w_r == end_w_r) begin
          state_nxt = ffa_pkg::S_FINISH;
        end else begin
          w_nxt = w_inc;
        end
      end

      ffa_pkg::S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_granted_r;
          out_start_nxt   = res_start_r;
          out_frag_nxt    = res_frag_r;
          out_count_nxt   = total_r;
          state_nxt       = ffa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ffa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mem_q     <= bitmap_mem[rd_addr];
    rd_addr_q <= rd_addr;
    if (wr_en) begin
      bitmap_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= '0;
    end else if (wr_en) begin
      word_valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffa_pkg::S_IDLE;
      pool_r      <= 9'd256;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_r      <= pool_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_set_r      <= op_set_nxt;
    cnt_r         <= cnt_nxt;
    w_r           <= w_nxt;
    end_w_r       <= end_w_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    carry_r       <= carry_nxt;
    res_granted_r <= res_granted_nxt;
    res_start_r   <= res_start_nxt;
    res_frag_r    <= res_frag_nxt;
    out_granted_r <= out_granted_nxt;
    out_start_r   <= out_start_nxt;
    out_frag_r    <= out_frag_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_granted_start = out_start_r;
  assign out_fragmented    = out_frag_r;
  assign out_in_use_count  = out_count_r;

endmodule

// File: tb/tb_first_fit_contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_first_fit_contiguous_block_allocator: self-checking bench of the allocator
// Drives allocate and free words through the valid/stall input channel. A
// bitmap model predicts each result word, and the monitor checks the output
// channel against it. The pool size is changed between phases, and both
// sides idle at random, with two long output hold-offs that back up the input.
// ----------------------------------------------------------------------------
module tb_first_fit_contiguous_block_allocator;

  localparam int NUM_BLOCKS = 256;
  localparam int RANDOM_PHASES = 10;
  localparam int WORDS_PER_PHASE = 190;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  // One input word, as it is put on the input ports.
  typedef struct packed {
    logic       cmd;
    logic [8:0] count;
    logic [7:0] start;
  } cmd_word_t;

  // One result word, in the order of the output ports.
  typedef struct packed {
    logic       granted;
    logic [7:0] start;
    logic       frag;
    logic [8:0] in_use;
  } alloc_result_t;

  // Bitmap of used blocks and the number of blocks in use.
  typedef struct {
    bit [NUM_BLOCKS-1:0] map;
    int unsigned         total;
  } pool_state_t;

  // A run handed out by the planner, kept so that later frees can return it.
  typedef struct packed {
    logic [7:0] first;
    logic [8:0] len;
  } granted_run_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_command = ffa_pkg::CMD_ALLOC;
  logic [8:0] in_block_count = '0;
  logic [7:0] in_run_start = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_granted;
  logic [7:0] out_granted_start;
  logic       out_fragmented;
  logic [8:0] out_in_use_count;

  first_fit_contiguous_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_block_count   (in_block_count),
    .in_run_start     (in_run_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted      (out_granted),
    .out_granted_start(out_granted_start),
    .out_fragmented   (out_fragmented),
    .out_in_use_count (out_in_use_count)
  );

  // Words waiting to be sent, and the results still owed by the allocator.
  cmd_word_t     cmd_queue[$];
  alloc_result_t expected_results[$];

  // The live state tracks what the allocator holds after every accepted word.
  // The plan state is a scratch copy the generator uses to aim frees at runs
  // that really are allocated.
  pool_state_t    live;
  pool_state_t    plan;
  logic [8:0]     pool_cfg = 9'd256;
  granted_run_t   held_runs[$];

  // When set, neither side idles, which gives stretches at full rate.
  bit calm = 1'b0;

  cmd_word_t sent_word;
  int        send_gap = 0;
  int        stall_left = 0;
  int        hold_left = 0;
  int        results_seen = 0;
  int        errors = 0;
  int        reported = 0;

  int n_granted = 0;
  int n_refused = 0;
  int n_fragmented = 0;
  int n_frees = 0;
  int n_zero = 0;
  int n_pool_settings = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one word to a bitmap state and returns the result word it yields.
  // First fit scans upward from block zero inside the effective pool, which
  // is the configured size limited to the size of the map.
  function automatic alloc_result_t run_command(inout pool_state_t s,
                                                input logic [8:0] pool,
                                                input cmd_word_t c);
    alloc_result_t r;
    int unsigned   eff;
    int unsigned   run;
    int unsigned   freeb;
    int unsigned   b;
    int unsigned   i;
    bit            found;
    r = '0;
    found = 1'b0;
    eff = (pool < NUM_BLOCKS) ? pool : NUM_BLOCKS;
    if (c.count != 0) begin
      if (c.cmd == ffa_pkg::CMD_ALLOC) begin
        run = 0;
        for (b = 0; b < eff && !found; b++) begin
          run = s.map[b] ? 0 : run + 1;
          if (run == c.count) begin
            found = 1'b1;
            r.start = 8'(b + 1 - c.count);
          end
        end
        if (found) begin
          for (i = 0; i < c.count; i++) s.map[int'(r.start) + i] = 1'b1;
          s.total += c.count;
          r.granted = 1'b1;
        end else begin
          // With the pool shrunk below the blocks in use the free total floors at zero.
          freeb = (s.total < eff) ? eff - s.total : 0;
          r.frag = (freeb >= c.count);
        end
      end else begin
        // Blocks past the end of the map are dropped; only used ones count.
        for (i = 0; i < c.count; i++) begin
          b = c.start + i;
          if (b >= NUM_BLOCKS) break;
          if (s.map[b]) begin
            s.map[b] = 1'b0;
            if (s.total > 0) s.total--;
          end
        end
        r.granted = 1'b1;
      end
    end
    r.in_use = s.total[8:0];
    return r;
  endfunction

  // Sender. A word stays on the ports until it is taken; after each accepted
  // word a random gap may follow. The prediction is made at acceptance, so
  // it always sees the state left by the word before.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        alloc_result_t want;
        want = run_command(live, pool_cfg, sent_word);
        expected_results.insert(expected_results.size(), want);
        if (sent_word.count == 0) n_zero++;
        else if (sent_word.cmd == ffa_pkg::CMD_FREE) n_frees++;
        else if (want.granted) n_granted++;
        else n_refused++;
        if (want.frag) n_fragmented++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        sent_word = cmd_queue.pop_front();
        in_command <= sent_word.cmd;
        in_block_count <= sent_word.count;
        in_run_start <= sent_word.start;
        in_valid <= 1'b1;
        send_gap = calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Each accepted result word is checked against the oldest
  // prediction. Twice in the run the receiver holds off for a long stretch
  // so that the allocator fills up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        alloc_result_t got;
        alloc_result_t want;
        got = '{out_granted, out_granted_start, out_fragmented, out_in_use_count};
        if (expected_results.size() == 0) begin
          errors++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("ERROR: result word with nothing expected: %s%0d %s%0d %s%0d %s%0d",
                     "granted=", got.granted, "start=", got.start,
                     "frag=", got.frag, "in_use=", got.in_use);
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (reported < MAX_REPORTS) begin
              reported++;
              $display("ERROR: result %0d: granted %0d/%0d start %0d/%0d frag %0d/%0d %s",
                       results_seen, want.granted, got.granted, want.start, got.start,
                       want.frag, got.frag, "(expected/actual)");
              $display("       in_use %0d/%0d (expected/actual)", want.in_use, got.in_use);
            end
          end
        end
        results_seen++;
        if (results_seen == 150 || results_seen == 1200) hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = calm ? 0 : pick_gap();
      end
    end
  end

  task automatic push_cmd(input logic cmd, input int unsigned count, input int unsigned start);
    cmd_word_t c;
    c = '{cmd, 9'(count), 8'(start)};
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  // Idle means nothing left to send, nothing on the input ports and no
  // result outstanding. Sampled at the falling edge, when all updates of the
  // rising edge have settled.
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pool(input logic [8:0] blocks);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= blocks;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_cfg = blocks;
    n_pool_settings++;
  endtask

  // Allocation lengths: mostly short runs, a few up to the whole pool, and
  // rarely zero or longer than the map can ever hold.
  function automatic int unsigned pick_alloc_len(input int unsigned eff);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 6) return $urandom_range(257, 511);
    if (r < 10) return $urandom_range(eff / 2 + 1, eff);
    if (r < 75) return $urandom_range(1, (eff < 8) ? eff : 8);
    return $urandom_range(1, (eff < 40) ? eff : 40);
  endfunction

  // Builds one phase of words. Most words are allocations or frees of runs
  // the planner knows to be held; the fuller the pool, the more frees. A
  // small share is noise with any command, length and start.
  task automatic gen_phase(input int n);
    int unsigned   eff;
    int unsigned   fill;
    int unsigned   idx;
    int            k;
    cmd_word_t     c;
    granted_run_t  gr;
    alloc_result_t res;
    eff = (pool_cfg < NUM_BLOCKS) ? pool_cfg : NUM_BLOCKS;
    plan = live;
    for (k = 0; k < n; k++) begin
      fill = plan.total * 100 / (eff + 1);
      if ($urandom_range(0, 99) < 7) begin
        c = '{1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255))};
      end else if (held_runs.size() != 0 && $urandom_range(0, 99) < fill + 10) begin
        idx = $urandom_range(0, held_runs.size() - 1);
        gr = held_runs[idx];
        held_runs.delete(idx);
        c = '{ffa_pkg::CMD_FREE, gr.len, gr.first};
      end else begin
        c = '{ffa_pkg::CMD_ALLOC, 9'(pick_alloc_len(eff)), 8'($urandom_range(0, 255))};
      end
      res = run_command(plan, pool_cfg, c);
      if (c.cmd == ffa_pkg::CMD_ALLOC && res.granted) begin
        gr = '{res.start, c.count};
        held_runs.insert(held_runs.size(), gr);
      end
      cmd_queue.insert(cmd_queue.size(), c);
    end
  endtask

  initial begin
    logic [8:0] phase_pool[RANDOM_PHASES];
    int         p;
    live.map = '0;
    live.total = 0;
    phase_pool = '{9'd256, 9'd1, 9'd511, 9'd64, 9'd17, 9'd256, 9'd130, 9'd2, 9'd255, 9'd256};
    phase_pool[7] = 9'($urandom_range(2, 256));

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset pool size of 256 blocks.
    push_cmd(ffa_pkg::CMD_ALLOC, 0, 0);      // zero count allocate: nothing changes
    push_cmd(ffa_pkg::CMD_FREE, 0, 255);     // zero count free: nothing changes
    push_cmd(ffa_pkg::CMD_ALLOC, 1, 0);
    push_cmd(ffa_pkg::CMD_FREE, 1, 0);
    push_cmd(ffa_pkg::CMD_ALLOC, 256, 0);    // the whole map as one run
    push_cmd(ffa_pkg::CMD_ALLOC, 1, 0);      // full pool: refused, not fragmented
    push_cmd(ffa_pkg::CMD_ALLOC, 511, 0);    // longer than the pool: refused
    push_cmd(ffa_pkg::CMD_FREE, 511, 255);   // runs past the end of the map
    push_cmd(ffa_pkg::CMD_FREE, 10, 10);
    push_cmd(ffa_pkg::CMD_FREE, 10, 100);
    push_cmd(ffa_pkg::CMD_ALLOC, 15, 0);     // 21 free blocks but no run of 15
    push_cmd(ffa_pkg::CMD_ALLOC, 10, 0);     // fits the first hole
    push_cmd(ffa_pkg::CMD_FREE, 256, 0);
    push_cmd(ffa_pkg::CMD_FREE, 5, 0);       // freeing blocks that are already free
    push_cmd(ffa_pkg::CMD_ALLOC, 200, 0);
    wait_idle();

    // Pool shrunk below the blocks in use; frees outside the pool still count.
    write_pool(9'd16);
    push_cmd(ffa_pkg::CMD_ALLOC, 4, 0);
    push_cmd(ffa_pkg::CMD_FREE, 4, 8);
    push_cmd(ffa_pkg::CMD_ALLOC, 4, 0);
    push_cmd(ffa_pkg::CMD_FREE, 1, 128);
    wait_idle();

    // An empty pool refuses every allocation.
    write_pool(9'd0);
    push_cmd(ffa_pkg::CMD_ALLOC, 1, 0);
    push_cmd(ffa_pkg::CMD_FREE, 256, 0);
    wait_idle();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_pool(phase_pool[p]);
      calm = (p != 0) && ($urandom_range(0, 3) == 0);
      gen_phase(WORDS_PER_PHASE);
      wait_idle();
    end

    calm = 1'b0;
    repeat (60) @(posedge clk);

    $display("Checked %0d result words over %0d pool sizes: %0d granted, %0d refused,",
             results_seen, n_pool_settings + 1, n_granted, n_refused);
    $display("%0d of them fragmented; %0d frees, %0d zero-length words, %0d mismatches.",
             n_fragmented, n_frees, n_zero, errors);
    if (errors == 0) begin
      $display("** first_fit_contiguous_block_allocator: PASSED **");
    end else begin
      $display("** first_fit_contiguous_block_allocator: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d words unsent and %0d results outstanding.",
             cmd_queue.size(), expected_results.size());
    $display("** first_fit_contiguous_block_allocator: FAILED **");
    $finish;
  end

endmodule

// File: first_fit_contiguous_block_allocator.f
src/ffa_pkg.sv
src/ffa_word_scan.sv
src/first_fit_contiguous_block_allocator.sv
tb/tb_first_fit_contiguous_block_allocator.sv
